[rtl/core/tlsrhd_pkg.sv]
// Shared constants for the TLS record and handshake deframer.
`timescale 1ns / 1ps
package tlsrhd_pkg;

   localparam logic [7:0] REC_CCS       = 8'd20;
   localparam logic [7:0] REC_ALERT     = 8'd21;
   localparam logic [7:0] REC_HANDSHAKE = 8'd22;
   localparam logic [7:0] REC_APP       = 8'd23;

   localparam logic [7:0] MSG_SERVER_HELLO = 8'd2;
   localparam logic [7:0] MSG_CERTIFICATE  = 8'd11;
   localparam logic [7:0] MSG_KEY_EXCHANGE = 8'd12;
   localparam logic [7:0] MSG_CERT_REQUEST = 8'd13;
   localparam logic [7:0] MSG_HELLO_DONE   = 8'd14;
   localparam logic [7:0] MSG_FINISHED     = 8'd20;

   localparam int HELLO_MIN_LEN  = 38;
   localparam int RANDOM_LEN     = 32;
   localparam int RECORD_HDR_LEN = 5;
   localparam int MSG_HDR_LEN    = 4;
   localparam int MAX_SESSION_ID = 32;

   typedef enum logic [2:0] {
      CONN_INIT     = 3'd0,
      CONN_HELLO    = 3'd1,
      CONN_CERT     = 3'd2,
      CONN_DONE     = 3'd3,
      CONN_CCS      = 3'd4,
      CONN_FINISHED = 3'd5,
      CONN_ERROR    = 3'd6
   } conn_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_RECORD   = 3'd1,
      EV_ALERT    = 3'd2,
      EV_CCS      = 3'd3,
      EV_DONE     = 3'd4,
      EV_FINISHED = 3'd5,
      EV_ERROR    = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_RANDOM = 3'd1,
      KIND_SID    = 3'd2,
      KIND_CERT   = 3'd3,
      KIND_APP    = 3'd4
   } kind_type;

   localparam logic csr_addr_app_enable = 1'b0;
   localparam logic csr_addr_init_len   = 1'b1;

endpackage

[rtl/core/tls_record_handshake_deframer.sv]
// Top level of the TLS record and handshake deframer.
`timescale 1ns / 1ps
// The deframer takes one received TLS byte per request and returns exactly one
// response per request. Each byte is parsed combinationally: the parser state is
// updated at the edge that accepts the request, and the response is written into
// the response register, or into the skid register while the response register
// is stalled. The single skid register absorbs one stall, and requests are
// stalled while it is full. Throughput is one byte per clock while the skid
// register is empty. Record headers (5 bytes) and handshake headers
// (4 bytes) are parsed, ServerHello version, suite and session ID length are
// captured, and random, session ID, certificate and (when enabled) application
// data bytes are forwarded. An error or alert halts the parser until a restart
// request. Configuration writes take effect at once and must only be made while
// the block is idle; writing initial_transcript_len also reloads the transcript
// fill level, clamped to TRANSCRIPT_BYTES.
module tls_record_handshake_deframer
   import tlsrhd_pkg::*;
#(
   parameter int TRANSCRIPT_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_conn_state,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_alert_sev,
   output logic [7:0]  rsp_alert_desc,
   output logic [15:0] rsp_proto_version,
   output logic [15:0] rsp_suite_code,
   output logic [5:0]  rsp_sid_length,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_byte_kind,
   output logic        rsp_transcript_keep,
   output logic [7:0]  rsp_transcript_byte,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int FW = $clog2(TRANSCRIPT_BYTES + 1);

   typedef enum logic [2:0] {
      PH_REC_HDR, PH_MSG_HDR, PH_MSG_BODY, PH_ALERT, PH_CCS, PH_APP, PH_HALT
   } phase_type;

   typedef struct packed {
      logic [2:0]  conn;
      logic [2:0]  ev;
      logic [7:0]  alvl;
      logic [7:0]  adesc;
      logic [15:0] ver;
      logic [15:0] suite;
      logic [5:0]  sid;
      logic [7:0]  dbyte;
      logic [2:0]  kind;
      logic        keep;
      logic [7:0]  tbyte;
   } rsp_type;

   // Configuration registers.
   logic        app_en_ff;
   logic [13:0] init_len_ff;

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic [7:0]  rkind_ff, rkind_in;
   logic [15:0] rleft_ff, rleft_in;
   logic [7:0]  mkind_ff, mkind_in;
   logic [23:0] mleft_ff, mleft_in;
   logic [15:0] moff_ff, moff_in;
   logic        save_ff, save_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [2:0]  conn_ff, conn_in;
   logic [15:0] ver_ff, ver_in, suite_ff, suite_in;
   logic [5:0]  sid_ff, sid_in;
   logic [7:0]  alvl_ff, alvl_in, adesc_ff, adesc_in;
   logic [2:0]  ev, kind;
   logic [7:0]  dbyte, tbyte;
   logic        keep;

   // Output register plus skid register.
   rsp_type     out_ff, skid_ff, res;
   logic        out_vld_ff, skid_vld_ff;

   logic        accept, cfg_wr;
   logic [FW-1:0] fill_start;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign req_stall  = skid_vld_ff;
   assign accept     = req_valid & ~skid_vld_ff;

   always_comb begin
      if ({{(32-14){1'b0}}, init_len_ff} < 32'(TRANSCRIPT_BYTES)) begin
         fill_start = FW'(init_len_ff);
      end else begin
         fill_start = FW'(TRANSCRIPT_BYTES);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == csr_addr_init_len) begin
         csr_prdata = {18'd0, init_len_ff};
      end else begin
         csr_prdata = {31'd0, app_en_ff};
      end
   end

   // One byte of parsing.
   always_comb begin
      logic [7:0]  b;
      logic [15:0] rl;
      logic [23:0] ml;
      logic        fail, fin, end_chk, keep_try;
      logic [15:0] o;
      logic [16:0] o17;
      b = req_rx_byte;
      phase_in = phase_ff; hcnt_in = hcnt_ff; rkind_in = rkind_ff;
      rleft_in = rleft_ff; mkind_in = mkind_ff; mleft_in = mleft_ff;
      moff_in = moff_ff; save_in = save_ff; fill_in = fill_ff;
      conn_in = conn_ff; ver_in = ver_ff; suite_in = suite_ff;
      sid_in = sid_ff; alvl_in = alvl_ff; adesc_in = adesc_ff;
      ev = EV_NONE; kind = KIND_NONE; dbyte = '0; keep = 1'b0; tbyte = '0;
      fail = 1'b0; fin = 1'b0; end_chk = 1'b0; keep_try = 1'b0;
      rl = rleft_ff; ml = mleft_ff; o = moff_ff;
      o17 = {1'b0, moff_ff};
      if (req_restart) begin
         phase_in = PH_REC_HDR; hcnt_in = '0; rkind_in = '0; rleft_in = '0;
         mkind_in = '0; mleft_in = '0; moff_in = '0; save_in = 1'b0;
         fill_in = fill_start; conn_in = CONN_INIT; ver_in = '0;
         suite_in = '0; sid_in = '0; alvl_in = '0; adesc_in = '0;
      end else begin
         unique case (phase_ff)
            PH_REC_HDR: begin
               if (hcnt_ff == 3'd0) rkind_in = b;
               if (hcnt_ff == 3'd3) rleft_in = {b, 8'd0};
               if (hcnt_ff == 3'd4) begin
                  rl = {rleft_ff[15:8], b};
                  rleft_in = rl;
               end
               hcnt_in = hcnt_ff + 3'd1;
               if (hcnt_ff == 3'(RECORD_HDR_LEN - 1)) begin
                  hcnt_in = '0;
                  moff_in = '0;
                  case (rkind_ff)
                     REC_HANDSHAKE: phase_in = PH_MSG_HDR;
                     REC_ALERT:     phase_in = PH_ALERT;
                     REC_CCS:       phase_in = PH_CCS;
                     REC_APP:       phase_in = PH_APP;
                     default:       fail = 1'b1;
                  endcase
                  end_chk = ~fail;
               end
            end
            PH_MSG_HDR: begin
               if (hcnt_ff == 3'd0) begin
                  mkind_in = b;
                  ml = '0;
                  save_in = (b == MSG_SERVER_HELLO) || (b == MSG_CERTIFICATE) ||
                            (b == MSG_KEY_EXCHANGE) || (b == MSG_CERT_REQUEST) ||
                            (b == MSG_HELLO_DONE);
               end else begin
                  ml = {mleft_ff[15:0], b};
               end
               mleft_in = ml;
               keep_try = 1'b1;
               rl = rleft_ff - 16'd1;
               rleft_in = rl;
               hcnt_in = hcnt_ff + 3'd1;
               if (hcnt_ff != 3'(MSG_HDR_LEN - 1)) begin
                  if (rl == 16'd0) fail = 1'b1;
               end else begin
                  hcnt_in = '0;
                  if (ml > {8'd0, rl} ||
                      (mkind_ff == MSG_SERVER_HELLO && ml < 24'(HELLO_MIN_LEN)) ||
                      (mkind_ff == MSG_CERTIFICATE && ml < 24'd3)) begin
                     fail = 1'b1;
                  end else begin
                     moff_in = '0;
                     if (ml == 24'd0) fin = 1'b1;
                     else phase_in = PH_MSG_BODY;
                  end
               end
            end
            PH_MSG_BODY: begin
               keep_try = 1'b1;
               if (mkind_ff == MSG_SERVER_HELLO) begin
                  if (o == 16'd0) ver_in = {b, ver_ff[7:0]};
                  else if (o == 16'd1) ver_in = {ver_ff[15:8], b};
                  else if (o17 < 17'(2 + RANDOM_LEN)) begin
                     kind = KIND_RANDOM; dbyte = b;
                  end else if (o17 == 17'(2 + RANDOM_LEN)) begin
                     if (b > 8'(MAX_SESSION_ID) ||
                         (mleft_ff - 24'd1) < ({16'd0, b} + 24'd2)) fail = 1'b1;
                     else sid_in = b[5:0];
                  end else if (o17 < 17'(3 + RANDOM_LEN) + {11'd0, sid_ff}) begin
                     kind = KIND_SID; dbyte = b;
                  end else if (o17 == 17'(3 + RANDOM_LEN) + {11'd0, sid_ff}) begin
                     suite_in = {b, suite_ff[7:0]};
                  end else if (o17 == 17'(4 + RANDOM_LEN) + {11'd0, sid_ff}) begin
                     suite_in = {suite_ff[15:8], b};
                  end
               end else if (mkind_ff == MSG_CERTIFICATE) begin
                  kind = KIND_CERT; dbyte = b;
               end
               if (!fail) begin
                  if (moff_ff != 16'hFFFF) moff_in = moff_ff + 16'd1;
                  mleft_in = mleft_ff - 24'd1;
                  rl = rleft_ff - 16'd1;
                  rleft_in = rl;
                  if (mleft_ff == 24'd1) fin = 1'b1;
               end
            end
            PH_ALERT, PH_CCS, PH_APP: begin
               rl = rleft_ff - 16'd1;
               if (phase_ff == PH_ALERT) begin
                  if (moff_ff == 16'd0 && rleft_ff >= 16'd2) alvl_in = b;
                  if (moff_ff == 16'd1) begin
                     adesc_in = b; conn_in = CONN_ERROR;
                     phase_in = PH_HALT; ev = EV_ALERT;
                  end
                  if (moff_ff != 16'hFFFF) moff_in = moff_ff + 16'd1;
               end else if (phase_ff == PH_CCS) begin
                  if (rleft_ff == 16'd1 && moff_ff == 16'd0 && b == 8'd1) begin
                     conn_in = CONN_CCS; ev = EV_CCS;
                  end
                  if (moff_ff != 16'hFFFF) moff_in = moff_ff + 16'd1;
               end else if (app_en_ff) begin
                  kind = KIND_APP; dbyte = b;
               end
               if (!(phase_ff == PH_ALERT && moff_ff == 16'd1)) begin
                  rleft_in = rl;
                  end_chk = 1'b1;
               end
            end
            default: ;
         endcase
         // Transcript append happens before any error on this byte.
         if (keep_try && save_in && fill_ff < FW'(TRANSCRIPT_BYTES)) begin
            keep = 1'b1; tbyte = b; fill_in = fill_ff + FW'(1);
         end
         if (fail) begin
            conn_in = CONN_ERROR; phase_in = PH_HALT; ev = EV_ERROR;
         end
         if (fin) begin
            case (mkind_ff)
               MSG_SERVER_HELLO: conn_in = CONN_HELLO;
               MSG_CERTIFICATE:  conn_in = CONN_CERT;
               MSG_HELLO_DONE: begin conn_in = CONN_DONE; ev = EV_DONE; end
               MSG_FINISHED: begin conn_in = CONN_FINISHED; ev = EV_FINISHED; end
               default: ;
            endcase
            phase_in = PH_MSG_HDR;
            hcnt_in = '0;
            end_chk = 1'b1;
         end
         if (end_chk && rl == 16'd0) begin
            phase_in = PH_REC_HDR;
            hcnt_in = '0;
            if (ev == EV_NONE) ev = EV_RECORD;
         end
      end
   end

   // Response fields for the byte being accepted.
   always_comb begin
      res.conn  = conn_in;   res.ev    = ev;
      res.alvl  = alvl_in;   res.adesc = adesc_in;
      res.ver   = ver_in;    res.suite = suite_in;
      res.sid   = sid_in;    res.dbyte = dbyte;
      res.kind  = kind;      res.keep  = keep;
      res.tbyte = tbyte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         app_en_ff <= 1'b0; init_len_ff <= '0;
         phase_ff <= PH_REC_HDR; hcnt_ff <= '0; rkind_ff <= '0; rleft_ff <= '0;
         mkind_ff <= '0; mleft_ff <= '0; moff_ff <= '0; save_ff <= 1'b0;
         fill_ff <= '0; conn_ff <= CONN_INIT; ver_ff <= '0; suite_ff <= '0;
         sid_ff <= '0; alvl_ff <= '0; adesc_ff <= '0;
         out_vld_ff <= 1'b0; skid_vld_ff <= 1'b0;
      end else begin
         if (cfg_wr && csr_paddr[2] == csr_addr_app_enable) app_en_ff <= csr_pwdata[0];
         if (cfg_wr && csr_paddr[2] == csr_addr_init_len) begin
            init_len_ff <= csr_pwdata[13:0];
            if (csr_pwdata[13:0] < 14'(TRANSCRIPT_BYTES > 16383 ? 16383 : TRANSCRIPT_BYTES)
                || TRANSCRIPT_BYTES > 16383) begin
               fill_ff <= FW'(csr_pwdata[13:0]);
            end else begin
               fill_ff <= FW'(TRANSCRIPT_BYTES);
            end
         end
         if (accept) begin
            phase_ff <= phase_in; hcnt_ff <= hcnt_in; rkind_ff <= rkind_in;
            rleft_ff <= rleft_in; mkind_ff <= mkind_in; mleft_ff <= mleft_in;
            moff_ff <= moff_in; save_ff <= save_in; fill_ff <= fill_in;
            conn_ff <= conn_in; ver_ff <= ver_in; suite_ff <= suite_in;
            sid_ff <= sid_in; alvl_ff <= alvl_in; adesc_ff <= adesc_in;
         end
         // Response register with one skid entry.
         if (!rsp_stall || !out_vld_ff) begin
            if (skid_vld_ff) begin
               out_ff <= skid_ff; out_vld_ff <= 1'b1; skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= accept;
               if (accept) out_ff <= res;
            end
         end else if (accept) begin
            skid_ff <= res; skid_vld_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_conn_state      = out_ff.conn;
   assign rsp_event_res       = out_ff.ev;
   assign rsp_alert_sev       = out_ff.alvl;
   assign rsp_alert_desc      = out_ff.adesc;
   assign rsp_proto_version   = out_ff.ver;
   assign rsp_suite_code      = out_ff.suite;
   assign rsp_sid_length      = out_ff.sid;
   assign rsp_data_byte       = out_ff.dbyte;
   assign rsp_byte_kind       = out_ff.kind;
   assign rsp_transcript_keep = out_ff.keep;
   assign rsp_transcript_byte = out_ff.tbyte;

   // The skid entry is only filled while the response register is full.
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid full with empty output");
   // The halted parser stays halted until a restart request.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT && !(accept && req_restart)) |=> phase_ff == PH_HALT)
      else $error("parser left halt without restart");
   // The transcript fill never passes its capacity.
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(TRANSCRIPT_BYTES)) else $error("transcript overflow");
   // An error state always comes with the halted parser.
   a_err_halt: assert property (@(posedge clock) disable iff (reset)
      conn_ff == CONN_ERROR |-> phase_ff == PH_HALT) else $error("error without halt");

endmodule

[test/tb_tls_record_handshake_deframer.sv]
// Self-checking testbench for the TLS record and handshake deframer.
`timescale 1ns / 1ps
module tb_tls_record_handshake_deframer;
   import tlsrhd_pkg::*;

   localparam int FILL_MAX = 8192;
   localparam int WATCHDOG_LIMIT = 20000;

   // Parser phases of the local prediction.
   typedef enum logic [2:0] {
      PH_REC_HDR, PH_MSG_HDR, PH_MSG_BODY, PH_ALERT, PH_CCS, PH_APP, PH_HALT
   } phase_type;

   // One predicted response.
   typedef struct packed {
      logic [2:0]  conn_state;
      logic [2:0]  event_res;
      logic [7:0]  alert_sev;
      logic [7:0]  alert_desc;
      logic [15:0] proto_version;
      logic [15:0] suite_code;
      logic [5:0]  sid_length;
      logic [7:0]  data_byte;
      logic [2:0]  byte_kind;
      logic        transcript_keep;
      logic [7:0]  transcript_byte;
   } deframe_out_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        req_restart;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_conn_state;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_alert_sev;
   logic [7:0]  rsp_alert_desc;
   logic [15:0] rsp_proto_version;
   logic [15:0] rsp_suite_code;
   logic [5:0]  rsp_sid_length;
   logic [7:0]  rsp_data_byte;
   logic [2:0]  rsp_byte_kind;
   logic        rsp_transcript_keep;
   logic [7:0]  rsp_transcript_byte;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tls_record_handshake_deframer dut (.*);

   // Predictor state: a private copy of the parser and its configuration.
   logic        cfg_app_enable;
   logic [13:0] cfg_init_len;
   phase_type   phase;
   int unsigned hdr_count, rec_kind, rec_left, msg_kind, msg_left, msg_offset;
   logic        save_msg;
   int unsigned fill;
   logic [2:0]  conn;
   logic [7:0]  cap_level, cap_desc;
   logic [15:0] cap_version, cap_suite;
   logic [5:0]  cap_sid;

   deframe_out_type expected_rsp_q[$];
   int          error_count;
   int          mismatch_count;
   int          idle_percent;
   bit          hold_rsp;
   int          quiet_cycles;
   deframe_out_type cur;

   // The clock runs from time zero.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned fill_start();
      return (cfg_init_len < FILL_MAX) ? cfg_init_len : FILL_MAX;
   endfunction

   task automatic restart_parser();
      phase = PH_REC_HDR;
      hdr_count = 0; rec_kind = 0; rec_left = 0;
      msg_kind = 0; msg_left = 0; msg_offset = 0; save_msg = 1'b0;
      fill = fill_start();
      conn = CONN_INIT;
      cap_level = 0; cap_desc = 0; cap_version = 0; cap_suite = 0; cap_sid = 0;
   endtask

   // An error sends the parser into its halted phase.
   task automatic parse_fail();
      conn = CONN_ERROR;
      phase = PH_HALT;
      cur.event_res = EV_ERROR;
   endtask

   task automatic keep_transcript(input logic [7:0] b);
      if (save_msg && fill < FILL_MAX) begin
         cur.transcript_keep = 1'b1;
         cur.transcript_byte = b;
         fill++;
      end
   endtask

   task automatic close_if_record_empty();
      if (rec_left == 0) begin
         phase = PH_REC_HDR;
         hdr_count = 0;
         if (cur.event_res == EV_NONE) cur.event_res = EV_RECORD;
      end
   endtask

   task automatic complete_message();
      case (msg_kind)
         MSG_SERVER_HELLO: conn = CONN_HELLO;
         MSG_CERTIFICATE:  conn = CONN_CERT;
         MSG_HELLO_DONE: begin
            conn = CONN_DONE; cur.event_res = EV_DONE;
         end
         MSG_FINISHED: begin
            conn = CONN_FINISHED; cur.event_res = EV_FINISHED;
         end
         default: ;
      endcase
      phase = PH_MSG_HDR;
      hdr_count = 0;
      close_if_record_empty();
   endtask

   // Computes the response to one byte and advances the predictor.
   task automatic predict_deframe(input logic [7:0] b, input logic rst);
      int unsigned sid;
      cur = '0;
      if (rst) restart_parser();
      else begin
         case (phase)
            PH_REC_HDR: begin
               if (hdr_count == 0) rec_kind = b;
               else if (hdr_count == 3) rec_left = b << 8;
               else if (hdr_count == 4) rec_left |= b;
               hdr_count++;
               if (hdr_count == RECORD_HDR_LEN) begin
                  hdr_count = 0;
                  msg_offset = 0;
                  case (rec_kind)
                     REC_HANDSHAKE: phase = PH_MSG_HDR;
                     REC_ALERT:     phase = PH_ALERT;
                     REC_CCS:       phase = PH_CCS;
                     REC_APP:       phase = PH_APP;
                     default:       parse_fail();
                  endcase
                  if (phase != PH_HALT) close_if_record_empty();
               end
            end
            PH_MSG_HDR: begin
               if (hdr_count == 0) begin
                  msg_kind = b;
                  msg_left = 0;
                  save_msg = (b == MSG_SERVER_HELLO || b == MSG_CERTIFICATE ||
                              b == MSG_KEY_EXCHANGE || b == MSG_CERT_REQUEST ||
                              b == MSG_HELLO_DONE);
               end else msg_left = ((msg_left << 8) | b) & 24'hFFFFFF;
               keep_transcript(b);
               rec_left--;
               hdr_count++;
               if (hdr_count < MSG_HDR_LEN) begin
                  if (rec_left == 0) parse_fail();
               end else begin
                  hdr_count = 0;
                  if (msg_left > rec_left ||
                      (msg_kind == MSG_SERVER_HELLO && msg_left < HELLO_MIN_LEN) ||
                      (msg_kind == MSG_CERTIFICATE && msg_left < 3)) parse_fail();
                  else begin
                     msg_offset = 0;
                     if (msg_left == 0) complete_message();
                     else phase = PH_MSG_BODY;
                  end
               end
            end
            PH_MSG_BODY: begin
               keep_transcript(b);
               sid = cap_sid;
               if (msg_kind == MSG_SERVER_HELLO) begin
                  if (msg_offset == 0) cap_version[15:8] = b;
                  else if (msg_offset == 1) cap_version[7:0] = b;
                  else if (msg_offset < 2 + RANDOM_LEN) begin
                     cur.byte_kind = KIND_RANDOM; cur.data_byte = b;
                  end else if (msg_offset == 2 + RANDOM_LEN) begin
                     if (b > MAX_SESSION_ID || msg_left - 1 < b + 2) parse_fail();
                     else cap_sid = b[5:0];
                  end else if (msg_offset < 3 + RANDOM_LEN + sid) begin
                     cur.byte_kind = KIND_SID; cur.data_byte = b;
                  end else if (msg_offset == 3 + RANDOM_LEN + sid) cap_suite[15:8] = b;
                  else if (msg_offset == 4 + RANDOM_LEN + sid) cap_suite[7:0] = b;
               end else if (msg_kind == MSG_CERTIFICATE) begin
                  cur.byte_kind = KIND_CERT; cur.data_byte = b;
               end
               if (phase != PH_HALT) begin
                  if (msg_offset < 16'hFFFF) msg_offset++;
                  msg_left--;
                  rec_left--;
                  if (msg_left == 0) complete_message();
               end
            end
            PH_ALERT, PH_CCS, PH_APP: begin
               if (phase == PH_ALERT) begin
                  if (msg_offset == 1) begin
                     cap_desc = b;
                     conn = CONN_ERROR;
                     phase = PH_HALT;
                     cur.event_res = EV_ALERT;
                  end else if (msg_offset == 0 && rec_left >= 2) cap_level = b;
                  if (phase != PH_HALT && msg_offset < 16'hFFFF) msg_offset++;
               end else if (phase == PH_CCS) begin
                  if (rec_left == 1 && msg_offset == 0 && b == 1) begin
                     conn = CONN_CCS; cur.event_res = EV_CCS;
                  end
                  if (msg_offset < 16'hFFFF) msg_offset++;
               end else if (cfg_app_enable) begin
                  cur.byte_kind = KIND_APP; cur.data_byte = b;
               end
               if (phase != PH_HALT) begin
                  rec_left--;
                  close_if_record_empty();
               end
            end
            default: ;
         endcase
      end
      cur.conn_state    = conn;
      cur.alert_sev     = cap_level;
      cur.alert_desc    = cap_desc;
      cur.proto_version = cap_version;
      cur.suite_code    = cap_suite;
      cur.sid_length    = cap_sid;
   endtask

   // Sends one byte: the prediction is queued when the request is accepted.
   // Valid stays high into the next request unless an idle gap is taken.
   task automatic send_byte(input logic [7:0] b, input logic rst);
      if ($urandom_range(99) < idle_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_percent) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      req_restart <= rst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_deframe(b, rst);
      expected_rsp_q.push_back(cur);
   endtask

   task automatic send_header(input logic [7:0] kind, input int unsigned len);
      send_byte(kind, 0);
      send_byte(8'h03, 0);
      send_byte(8'h03, 0);
      send_byte(len[15:8], 0);
      send_byte(len[7:0], 0);
   endtask

   // A handshake record holding one message of the given type and body length.
   task automatic send_message_record(input logic [7:0] mt, input int unsigned len,
                                      input int unsigned sid);
      send_header(REC_HANDSHAKE, len + 4);
      send_byte(mt, 0);
      send_byte(len[23:16], 0);
      send_byte(len[15:8], 0);
      send_byte(len[7:0], 0);
      for (int i = 0; i < len; i++) begin
         if (mt == MSG_SERVER_HELLO && i == 34) send_byte(sid[7:0], 0);
         else send_byte(8'($urandom_range(255)), 0);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == {csr_addr_app_enable, 2'b00}) cfg_app_enable = data[0];
      else begin
         cfg_init_len = data[13:0];
         fill = fill_start();
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic app_en, input logic [13:0] init_len);
      wait_drained();
      csr_write({csr_addr_app_enable, 2'b00}, {31'd0, app_en});
      csr_write({csr_addr_init_len, 2'b00}, {18'd0, init_len});
   endtask

   // Directed flow: a full handshake followed by CCS and application records, an alert and a broken record.
   task automatic test_directed();
      send_byte(8'h00, 1);
      send_message_record(MSG_SERVER_HELLO, 38, 0);
      send_message_record(MSG_CERTIFICATE, 3, 0);
      send_message_record(MSG_HELLO_DONE, 0, 0);
      send_header(REC_CCS, 1);
      send_byte(8'h01, 0);
      send_header(REC_APP, 2);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_header(REC_ALERT, 2);
      send_byte(8'h02, 0);
      send_byte(8'h28, 0);
      send_byte(8'hAA, 0);
      send_byte(8'h00, 1);
      send_header(8'h63, 0);
   endtask

   task automatic test_server_hello();
      send_byte(8'h00, 1);
      send_message_record(MSG_SERVER_HELLO, 38 + 32, 32);
      send_byte(8'h00, 1);
      send_message_record(MSG_SERVER_HELLO, 40, 33);
      send_byte(8'h00, 1);
      send_message_record(MSG_SERVER_HELLO, 38, 1);
      send_byte(8'h00, 1);
      send_message_record(MSG_SERVER_HELLO, 20, 0);
      send_byte(8'h00, 1);
      send_message_record(MSG_CERTIFICATE, 2, 0);
   endtask

   // Well-formed sequences with random content, mixed with noise.
   task automatic test_random(input int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(19);
         len = $urandom_range(12);
         if (pick < 1) begin
            send_byte(8'($urandom_range(255)), 1); sent += 1;
         end else if (pick < 5) begin
            send_message_record(MSG_SERVER_HELLO, 38 + len + 2, len);
            sent += 49 + len;
         end else if (pick < 8) begin
            send_message_record(MSG_CERTIFICATE, 3 + len, 0); sent += 12 + len;
         end else if (pick < 10) begin
            send_message_record(($urandom_range(1)) ? MSG_HELLO_DONE : MSG_FINISHED,
                                len, 0);
            sent += 9 + len;
         end else if (pick < 11) begin
            send_message_record(8'(MSG_KEY_EXCHANGE + $urandom_range(1)), len, 0);
            sent += 9 + len;
         end else if (pick < 13) begin
            send_header(REC_APP, len);
            repeat (len) send_byte(8'($urandom_range(255)), 0);
            sent += 5 + len;
         end else if (pick < 14) begin
            send_header(REC_CCS, len % 3);
            repeat (len % 3) send_byte(8'($urandom_range(1)), 0);
            sent += 7;
         end else if (pick < 15) begin
            send_header(REC_ALERT, len % 4);
            repeat (len % 4) send_byte(8'($urandom_range(255)), 0);
            sent += 8;
            send_byte(0, 1);
         end else begin
            send_byte(8'($urandom_range(255)), 0); sent += 1;
         end
      end
   endtask

   // Response checker.
   always @(posedge clock) begin
      deframe_out_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_conn_state, rsp_event_res, rsp_alert_sev, rsp_alert_desc,
                rsp_proto_version, rsp_suite_code, rsp_sid_length, rsp_data_byte,
                rsp_byte_kind, rsp_transcript_keep, rsp_transcript_byte};
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            $display("unexpected response %h", got);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got !== want) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   // Receiver stall: random, or held for a long stretch when asked.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < idle_percent);
   end

   // Watchdog on cycles without any accepted request, response or CSR access.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("tls_record_handshake_deframer test failed");
         $finish;
      end
   end

   // Long receiver hold-off while the sender keeps offering requests.
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end
         test_random(80);
      join
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_rx_byte = '0; req_restart = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      hold_rsp = 1'b0; quiet_cycles = 0;
      error_count = 0; mismatch_count = 0; idle_percent = 26;
      cfg_app_enable = 1'b0; cfg_init_len = '0;
      restart_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      configure(1'b1, 14'd0);
      test_directed();
      test_server_hello();
      configure(1'b0, 14'd8190);
      test_directed();
      test_random(200);
      configure(1'b1, 14'd16383);
      test_random(150);
      configure(1'b1, 14'd8000);
      idle_percent = 0;
      test_random(300);
      idle_percent = 26;
      test_backpressure();
      configure(1'b0, 14'd100);
      test_random(250);
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("tls_record_handshake_deframer test passed");
      else $display("tls_record_handshake_deframer test failed");
      $finish;
   end

endmodule
